// File: sv/amse_pkg.sv
// Shared types and constants for the ARM move/shift execute block.
// No dependencies; imported by amse_exec and arm_move_shift_execute.
package amse_pkg;

  localparam int unsigned WordBits  = 32;
  localparam int unsigned ShiftBits = 8;

  typedef enum logic [2:0] {
    KIND_MOV_IMM = 3'd0,
    KIND_MOV_REG = 3'd1,
    KIND_MVN_REG = 3'd2,
    KIND_MOVT    = 3'd3,
    KIND_LSL_IMM = 3'd4,
    KIND_LSR_IMM = 3'd5,
    KIND_LSL_REG = 3'd6
  } kind_e;

  localparam logic [3:0] PcReg = 4'd15;

  // NZCV bit positions
  localparam int unsigned FlagN = 3;
  localparam int unsigned FlagZ = 2;
  localparam int unsigned FlagC = 1;
  localparam int unsigned FlagV = 0;

  typedef struct packed {
    logic [2:0]           kind;
    logic [3:0]           cond;
    logic                 set_flags;
    logic [3:0]           dest_reg;
    logic [WordBits-1:0]  operand_value;
    logic [ShiftBits-1:0] shift_amount;
    logic [WordBits-1:0]  old_dest_value;
    logic                 imm_carry;
    logic [WordBits-1:0]  pc_value;
  } req_t;

  typedef struct packed {
    logic                passed;
    logic                reg_write;
    logic [3:0]          write_reg;
    logic [WordBits-1:0] result_value;
    logic [WordBits-1:0] next_pc;
    logic [3:0]          flags_nzcv;
    logic                thumb_state;
    logic                branch_fault;
  } rsp_t;

  // Architectural state carried between instructions.
  typedef struct packed {
    logic [3:0] nzcv;
    logic       thumb;
  } status_t;

endpackage

// File: sv/amse_exec.sv
// Combinational execute datapath: condition check, shifter, flags, PC write.
// Depends on amse_pkg.
module amse_exec import amse_pkg::*; (
  input  req_t    req_i,
  input  status_t status_i,
  output rsp_t    rsp_o,
  output status_t status_o
);

  logic                cond_base;
  logic                cond_ok;
  logic                n_f, z_f, c_f, v_f;
  logic [WordBits-1:0] sh_res;
  logic                sh_carry;
  logic                sh_right;
  logic [WordBits:0]   sh_wide;
  logic [WordBits-1:0] result;
  logic                carry;
  logic                flags_ok;
  logic                valid_kind;
  logic                passed;
  logic [3:0]          nzcv_new;

  assign n_f = status_i.nzcv[FlagN];
  assign z_f = status_i.nzcv[FlagZ];
  assign c_f = status_i.nzcv[FlagC];
  assign v_f = status_i.nzcv[FlagV];

  always_comb begin
    unique case (req_i.cond[3:1])
      3'd0: cond_base = z_f;
      3'd1: cond_base = c_f;
      3'd2: cond_base = n_f;
      3'd3: cond_base = v_f;
      3'd4: cond_base = c_f & ~z_f;
      3'd5: cond_base = (n_f == v_f);
      3'd6: cond_base = ~z_f & (n_f == v_f);
      default: cond_base = 1'b1;
    endcase
    if (req_i.cond[3:1] == 3'd7) begin
      cond_ok = 1'b1;
    end else begin
      cond_ok = req_i.cond[0] ? ~cond_base : cond_base;
    end
  end

  // Shift_C for LSL/LSR, counts 0..255
  assign sh_right = (req_i.kind == KIND_LSR_IMM);

  always_comb begin
    sh_wide = '0;
    if (req_i.shift_amount == '0) begin
      sh_res   = req_i.operand_value;
      sh_carry = c_f;
    end else if (req_i.shift_amount > ShiftBits'(WordBits)) begin
      sh_res   = '0;
      sh_carry = 1'b0;
    end else if (req_i.shift_amount == ShiftBits'(WordBits)) begin
      sh_res   = '0;
      sh_carry = sh_right ? req_i.operand_value[WordBits-1] : req_i.operand_value[0];
    end else if (sh_right) begin
      sh_wide  = {req_i.operand_value, 1'b0} >> req_i.shift_amount[4:0];
      sh_res   = sh_wide[WordBits:1];
      sh_carry = sh_wide[0];
    end else begin
      sh_wide  = {1'b0, req_i.operand_value} << req_i.shift_amount[4:0];
      sh_res   = sh_wide[WordBits-1:0];
      sh_carry = sh_wide[WordBits];
    end
  end

  always_comb begin
    valid_kind = 1'b1;
    flags_ok   = 1'b1;
    carry      = c_f;
    result     = '0;
    unique case (req_i.kind)
      KIND_MOV_IMM: begin
        result = req_i.operand_value;
        carry  = req_i.imm_carry;
      end
      KIND_MOV_REG: result = req_i.operand_value;
      KIND_MVN_REG: begin
        result = ~sh_res;
        carry  = sh_carry;
      end
      KIND_MOVT: begin
        result   = {req_i.operand_value[15:0], req_i.old_dest_value[15:0]};
        flags_ok = 1'b0;
      end
      KIND_LSL_IMM, KIND_LSR_IMM, KIND_LSL_REG: begin
        result = sh_res;
        carry  = sh_carry;
      end
      default: valid_kind = 1'b0;
    endcase
  end

  assign passed = valid_kind & cond_ok;

  always_comb begin
    nzcv_new        = status_i.nzcv;
    nzcv_new[FlagN] = result[WordBits-1];
    nzcv_new[FlagZ] = (result == '0);
    nzcv_new[FlagC] = carry;
  end

  always_comb begin
    status_o           = status_i;
    rsp_o.passed       = passed;
    rsp_o.reg_write    = 1'b0;
    rsp_o.write_reg    = req_i.dest_reg;
    rsp_o.result_value = passed ? result : '0;
    rsp_o.next_pc      = req_i.pc_value + WordBits'(4);
    rsp_o.branch_fault = 1'b0;
    if (passed) begin
      if (req_i.dest_reg == PcReg) begin
        if (result[0]) begin
          status_o.thumb = 1'b1;
          rsp_o.next_pc  = {result[WordBits-1:1], 1'b0};
        end else if (!result[1]) begin
          status_o.thumb = 1'b0;
          rsp_o.next_pc  = result;
        end else begin
          rsp_o.branch_fault = 1'b1;
          rsp_o.next_pc      = result;
        end
      end else begin
        rsp_o.reg_write = 1'b1;
        if (req_i.set_flags && flags_ok) begin
          status_o.nzcv = nzcv_new;
        end
      end
    end
    rsp_o.flags_nzcv  = status_o.nzcv;
    rsp_o.thumb_state = status_o.thumb;
  end

endmodule

// File: sv/arm_move_shift_execute.sv
// ARM move/shift execute stage, top level.
// Pipeline: input register, then result register, which loads when empty or taken.
// Throughput: one request per cycle unless out_ready_i stalls; the single execute pass
//   between the registers sets this, with flags forwarded from the state register.
// Reset: rst_ni async low clears both stage valids, NZCV to 0 and ARM state.
// Depends on amse_pkg and amse_exec.
module arm_move_shift_execute import amse_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  logic    req_valid_q;
  req_t    req_q;
  logic    rsp_valid_q;
  rsp_t    rsp_q;
  status_t status_q, status_d;
  rsp_t    rsp_d;
  logic    advance;

  assign advance    = req_valid_q & (~rsp_valid_q | out_ready_i);
  assign in_ready_o = ~req_valid_q | advance;

  amse_exec u_exec (
    .req_i    (req_q),
    .status_i (status_q),
    .rsp_o    (rsp_d),
    .status_o (status_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      status_q    <= '0;
    end else begin
      if (in_ready_o) begin
        req_valid_q <= in_valid_i;
      end
      if (advance) begin
        rsp_valid_q <= 1'b1;
        status_q    <= status_d;
      end else if (out_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign out_rsp_o   = rsp_q;

  // V is never written by these instructions
  a_v_flag_const: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> $stable(status_q.nzcv[FlagV]))
    else $error("V flag changed");

  a_write_needs_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.reg_write |->
      out_rsp_o.passed && (out_rsp_o.write_reg != PcReg))
    else $error("register write without pass or to PC");

  a_fault_is_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.branch_fault |->
      out_rsp_o.passed && !out_rsp_o.reg_write)
    else $error("branch fault on non-PC write");

  a_flags_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_rsp_o.flags_nzcv == status_q.nzcv) &&
      (out_rsp_o.thumb_state == status_q.thumb))
    else $error("result flags differ from state");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("stalled with empty result register");

endmodule
